### hw/rtl/pdtq_pkg.sv
// ----------------------------------------------------------------------------
// pdtq_pkg
// Shared constants and types for the priority-ordered delay task queue.
// ----------------------------------------------------------------------------
package pdtq_pkg;

    // Table depth and scheduler tick length in milliseconds.
    localparam int MAX_TASKS = 16;
    localparam int TICK_MS   = 10;

    // Field widths of the input and result words.
    localparam int DLY_W  = 16;
    localparam int PRIO_W = 8;
    localparam int TAG_W  = 8;

    // Derived widths.
    localparam int IDX_W   = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int TICKS_W = $clog2(((1 << DLY_W) - 1) / TICK_MS + 1);

    // Division by the tick length as a multiplication by its rounded-up
    // reciprocal. With the shift set to the delay width plus the bit length
    // of the divisor, the truncated quotient is exact for every delay.
    localparam int RECIP_SH = DLY_W + $clog2(TICK_MS);
    localparam int RECIP_W  = DLY_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));
    localparam int PROD_W   = RECIP_SH + TICKS_W;

    // Command codes of the input word.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Kind codes of the result word.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    // One stored task.
    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic [PRIO_W-1:0]  prio;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV     = 6'b000010,
        ST_INS_RD  = 6'b000100,
        ST_INS_CHK = 6'b001000,
        ST_TICK    = 6'b010000,
        ST_ACK     = 6'b100000
    } t_state;

endpackage

### hw/rtl/priority_delay_task_queue_top.sv
// ----------------------------------------------------------------------------
// priority_delay_task_queue_top
// Delay task queue kept in priority order in a single synchronous memory.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_valid / o_ready) takes one word per command:
// an add word carries a delay in milliseconds, a priority and a tag, and a
// tick word advances the scheduler by one tick. The output channel
// (o_valid / i_ready) returns result words: one acknowledgement per add
// (dropped set when the table is full), and one word per task that fires
// on a tick, in table order, with o_last set on the final one. A tick on
// which nothing is due returns no word at all.
// Sequencing. A tick walks the table through the memory's one read port,
// one entry per cycle unless a stall pauses the walk.
// An add first divides the delay by the tick length (a multiply by the
// reciprocal), then moves each stored entry of higher priority value up by
// one place (read, then write back), then places the new task and sends
// the acknowledgement. A dropped add goes straight to the acknowledgement.
// One command is worked on at a time; o_ready is high when the sequencer
// is idle.
// Reset clears the task count and all control state; the table contents
// are left as they are and are never read before being written.
// When the receiver stalls, a finished word waits in the output register
// while the walk goes on; the walk pauses only when a second fired task
// is found while both the output register and the hold stage are full.
// ----------------------------------------------------------------------------
module priority_delay_task_queue_top
    import pdtq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_command,
    input  logic [DLY_W-1:0]  i_wait_ms,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [TAG_W-1:0]  i_task_tag,
    // Output channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic              o_dropped,
    output logic [TAG_W-1:0]  o_fired_tag,
    output logic [PRIO_W-1:0] o_fired_priority,
    output logic              o_last
);

    // ---------------------------------------------------------------------
    // Registers and their next values.
    // ---------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PRIO_W-1:0]  r_prio, n_prio;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic               r_drop, n_drop;
    logic [DLY_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]   r_ins_i, n_ins_i;
    logic [CNT_W-1:0]   r_issue, n_issue;
    logic [CNT_W-1:0]   r_wr, n_wr;
    logic               r_dv, n_dv;
    logic               r_pend_valid, n_pend_valid;
    logic [TAG_W-1:0]   r_pend_tag, n_pend_tag;
    logic [PRIO_W-1:0]  r_pend_prio, n_pend_prio;
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic               r_out_dropped, n_out_dropped;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [PRIO_W-1:0]  r_out_prio, n_out_prio;
    logic               r_out_last, n_out_last;

    // Task table and its registered read data.
    t_entry             r_task_table [MAX_TASKS];
    t_entry             r_rdata;

    // Memory port controls.
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    // Helpers.
    logic               in_accept;
    logic               out_free;
    logic [PROD_W-1:0]  quo_prod;
    logic [CNT_W-1:0]   ins_prev;
    t_entry             new_entry;
    logic               fire;
    logic               stall;

    assign o_ready   = (r_state == ST_IDLE);
    assign in_accept = i_valid && o_ready;
    // The output register can take a word when empty or being drained.
    assign out_free  = !r_out_valid || i_ready;

    // Delay times the reciprocal of the tick length; the quotient sits
    // above the shift.
    assign quo_prod  = PROD_W'(r_quo) * PROD_W'(RECIP_M);

    assign ins_prev  = r_ins_i - CNT_W'(1);

    always_comb begin
        new_entry.ticks = r_quo[TICKS_W-1:0];
        new_entry.prio  = r_prio;
        new_entry.tag   = r_tag;
    end

    // A due task is found; it can only be taken if the hold stage can
    // hand its previous task to the output register.
    assign fire  = (r_state == ST_TICK) && r_dv && (r_rdata.ticks == '0);
    assign stall = fire && r_pend_valid && !out_free;

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_prio        = r_prio;
        n_tag         = r_tag;
        n_drop        = r_drop;
        n_quo         = r_quo;
        n_ins_i       = r_ins_i;
        n_issue       = r_issue;
        n_wr          = r_wr;
        n_dv          = r_dv;
        n_pend_valid  = r_pend_valid;
        n_pend_tag    = r_pend_tag;
        n_pend_prio   = r_pend_prio;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_kind    = r_out_kind;
        n_out_dropped = r_out_dropped;
        n_out_tag     = r_out_tag;
        n_out_prio    = r_out_prio;
        n_out_last    = r_out_last;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_command == CMD_TICK) begin
                        n_issue = '0;
                        n_wr    = '0;
                        n_dv    = 1'b0;
                        n_state = ST_TICK;
                    end else if (r_count >= CNT_W'(MAX_TASKS)) begin
                        n_drop  = 1'b1;
                        n_state = ST_ACK;
                    end else begin
                        n_drop  = 1'b0;
                        n_prio  = i_priority_req;
                        n_tag   = i_task_tag;
                        n_quo   = i_wait_ms;
                        n_state = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                n_quo   = DLY_W'(quo_prod[PROD_W-1:RECIP_SH]);
                n_ins_i = r_count;
                n_state = ST_INS_RD;
            end

            ST_INS_RD: begin
                if (r_ins_i == '0) begin
                    // Every stored task has a higher priority value.
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = new_entry;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = ST_ACK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ins_prev[IDX_W-1:0];
                    n_state   = ST_INS_CHK;
                end
            end

            ST_INS_CHK: begin
                mem_we    = 1'b1;
                mem_waddr = r_ins_i[IDX_W-1:0];
                if (r_rdata.prio > r_prio) begin
                    // Move the entry up one place and keep searching.
                    mem_wdata = r_rdata;
                    n_ins_i   = ins_prev;
                    n_state   = ST_INS_RD;
                end else begin
                    // Equal priority stays ahead, so the new task goes here.
                    mem_wdata = new_entry;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = ST_ACK;
                end
            end

            ST_TICK: begin
                // Compact surviving entries toward the start of the table.
                if (r_dv && !fire) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_wr[IDX_W-1:0];
                    mem_wdata       = r_rdata;
                    mem_wdata.ticks = r_rdata.ticks - TICKS_W'(1);
                    n_wr            = r_wr + CNT_W'(1);
                end
                if (fire && !stall) begin
                    if (r_pend_valid) begin
                        n_out_valid   = 1'b1;
                        n_out_kind    = KIND_FIRE;
                        n_out_dropped = 1'b0;
                        n_out_tag     = r_pend_tag;
                        n_out_prio    = r_pend_prio;
                        n_out_last    = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_tag   = r_rdata.tag;
                    n_pend_prio  = r_rdata.prio;
                end
                if (!stall) begin
                    if (r_issue < r_count) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_issue[IDX_W-1:0];
                        n_issue   = r_issue + CNT_W'(1);
                        n_dv      = 1'b1;
                    end else begin
                        n_dv = 1'b0;
                    end
                end
                // Walk finished: release the held task as the last word.
                if (!r_dv && (r_issue == r_count)) begin
                    if (r_pend_valid) begin
                        if (out_free) begin
                            n_out_valid   = 1'b1;
                            n_out_kind    = KIND_FIRE;
                            n_out_dropped = 1'b0;
                            n_out_tag     = r_pend_tag;
                            n_out_prio    = r_pend_prio;
                            n_out_last    = 1'b1;
                            n_pend_valid  = 1'b0;
                            n_count       = r_wr;
                            n_state       = ST_IDLE;
                        end
                    end else begin
                        n_count = r_wr;
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_ACK: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = KIND_ACK;
                    n_out_dropped = r_drop;
                    n_out_tag     = '0;
                    n_out_prio    = '0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_ins_i      <= '0;
            r_issue      <= '0;
            r_wr         <= '0;
            r_dv         <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_ins_i      <= n_ins_i;
            r_issue      <= n_issue;
            r_wr         <= n_wr;
            r_dv         <= n_dv;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prio        <= n_prio;
        r_tag         <= n_tag;
        r_drop        <= n_drop;
        r_quo         <= n_quo;
        r_pend_tag    <= n_pend_tag;
        r_pend_prio   <= n_pend_prio;
        r_out_kind    <= n_out_kind;
        r_out_dropped <= n_out_dropped;
        r_out_tag     <= n_out_tag;
        r_out_prio    <= n_out_prio;
        r_out_last    <= n_out_last;
    end

    // Task table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_task_table[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_task_table[mem_raddr];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_dropped        = r_out_dropped;
    assign o_fired_tag      = r_out_tag;
    assign o_fired_priority = r_out_prio;
    assign o_last           = r_out_last;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TASKS))
        else $error("task count above table depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> (r_wr <= r_issue))
        else $error("compaction write passed the read pointer");

    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == ST_TICK))
        else $error("held fired task outside a tick walk");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ACK) && r_drop) |-> (r_count == CNT_W'(MAX_TASKS)))
        else $error("add dropped while the table had room");

    a_ack_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ACK) && out_free) |=>
            (r_out_valid && r_out_last && (r_out_kind == KIND_ACK)))
        else $error("acknowledgement word not loaded");

endmodule
